// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/rslm_pkg.sv =====
package rslm_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam logic FUNC_SEND = 1'b0;
    localparam logic FUNC_RECV = 1'b1;

    // rtt value reported when no ring slot matches
    localparam logic signed [63:0] RTT_NONE = -64'sd1;

    typedef struct packed {
        logic [31:0]        seq;
        logic signed [63:0] stamp;
    } ring_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic write_send;
        logic capture_recv;
        logic accumulate;
        logic read;
        logic take_match;
        logic scan_next;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic ack_nonzero;
        logic ring_empty;
        logic hit;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/rslm_ctrl.sv =====
module rslm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              func,
    input  rslm_pkg::status_t status,
    output rslm_pkg::cmd_t    cmd,
    output logic              item_stall
);

    rslm_pkg::state_t state_reg;
    rslm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rslm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rslm_pkg::ST_IDLE:
            begin
                if (item_valid && (func == rslm_pkg::FUNC_RECV))
                begin
                    state_next = rslm_pkg::ST_ACCUM;
                end
            end
            rslm_pkg::ST_ACCUM:
            begin
                if (status.ack_nonzero && !status.ring_empty)
                begin
                    state_next = rslm_pkg::ST_READ;
                end
                else
                begin
                    state_next = rslm_pkg::ST_EMIT;
                end
            end
            rslm_pkg::ST_READ:
            begin
                state_next = rslm_pkg::ST_CMP;
            end
            rslm_pkg::ST_CMP:
            begin
                if (status.hit || status.scan_last)
                begin
                    state_next = rslm_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rslm_pkg::ST_READ;
                end
            end
            rslm_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = rslm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rslm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            rslm_pkg::ST_IDLE:
            begin
                item_stall        = 1'b0;
                cmd.write_send    = item_valid && (func == rslm_pkg::FUNC_SEND);
                cmd.capture_recv  = item_valid && (func == rslm_pkg::FUNC_RECV);
            end
            rslm_pkg::ST_ACCUM:
            begin
                cmd.accumulate = 1'b1;
            end
            rslm_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            rslm_pkg::ST_CMP:
            begin
                cmd.take_match = status.hit;
                cmd.scan_next  = !status.hit && !status.scan_last;
            end
            rslm_pkg::ST_EMIT:
            begin
                cmd.load_result = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/rslm_datapath.sv =====
module rslm_datapath
#(
    parameter int RING_DEPTH = rslm_pkg::RING_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rslm_pkg::cmd_t      cmd,
    output rslm_pkg::status_t   status,
    input  logic [31:0]         seq_number,
    input  logic signed [63:0]  time_ns,
    input  logic [31:0]         acked_seq,
    input  logic                result_stall,
    output logic                result_valid,
    output logic signed [63:0]  rtt_ns,
    output logic                rtt_found,
    output logic [31:0]         gap_loss,
    output logic [63:0]         loss_total,
    output logic [63:0]         receive_count,
    output logic [63:0]         rtt_sample_count
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    rslm_pkg::ring_entry_t ring_mem [RING_DEPTH];

    logic [IDX_W-1:0]      head_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [31:0]           last_peer_reg;
    logic                  peer_seen_reg;
    logic [63:0]           loss_sum_reg;
    logic [63:0]           rows_reg;
    logic [63:0]           matches_reg;
    logic                  out_valid_reg;

    logic signed [63:0]    time_hold_reg;
    logic [31:0]           ack_hold_reg;
    logic [31:0]           gap_reg;
    logic [IDX_W-1:0]      scan_reg;
    rslm_pkg::ring_entry_t rd_entry_reg;
    logic signed [63:0]    rtt_reg;
    logic                  found_reg;

    logic signed [63:0]    rtt_ns_reg;
    logic                  rtt_found_reg;
    logic [31:0]           gap_loss_reg;
    logic [63:0]           loss_total_reg;
    logic [63:0]           receive_count_reg;
    logic [63:0]           rtt_sample_count_reg;

    logic [31:0]           expected;
    logic [31:0]           gap_next;

    assign expected = last_peer_reg + 32'd1;
    assign gap_next = (peer_seen_reg && (seq_number > expected)) ?
                      (seq_number - expected) : 32'd0;

    // slots at or beyond the fill count were never written since reset
    assign status.ack_nonzero = (ack_hold_reg != 32'd0);
    assign status.ring_empty  = (fill_reg == '0);
    assign status.hit         = (rd_entry_reg.seq == ack_hold_reg);
    assign status.scan_last   = (CNT_W'(scan_reg) == (fill_reg - CNT_W'(1)));
    assign status.out_free    = !out_valid_reg || !result_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.write_send)
        begin
            ring_mem[head_reg] <= '{seq: seq_number, stamp: time_ns};
        end
        if (cmd.read)
        begin
            rd_entry_reg <= ring_mem[scan_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            last_peer_reg <= '0;
            peer_seen_reg <= 1'b0;
            loss_sum_reg  <= '0;
            rows_reg      <= '0;
            matches_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_send)
            begin
                if (head_reg == IDX_W'(RING_DEPTH - 1))
                begin
                    head_reg <= '0;
                end
                else
                begin
                    head_reg <= head_reg + IDX_W'(1);
                end
                if (fill_reg != CNT_W'(RING_DEPTH))
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if (cmd.capture_recv)
            begin
                last_peer_reg <= seq_number;
                peer_seen_reg <= 1'b1;
            end
            if (cmd.accumulate)
            begin
                loss_sum_reg <= loss_sum_reg + {32'd0, gap_reg};
                rows_reg     <= rows_reg + 64'd1;
            end
            if (cmd.take_match)
            begin
                matches_reg <= matches_reg + 64'd1;
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_recv)
        begin
            time_hold_reg <= time_ns;
            ack_hold_reg  <= acked_seq;
            gap_reg       <= gap_next;
        end
        if (cmd.accumulate)
        begin
            scan_reg  <= '0;
            rtt_reg   <= rslm_pkg::RTT_NONE;
            found_reg <= 1'b0;
        end
        if (cmd.scan_next)
        begin
            scan_reg <= scan_reg + IDX_W'(1);
        end
        if (cmd.take_match)
        begin
            rtt_reg   <= time_hold_reg - rd_entry_reg.stamp;
            found_reg <= 1'b1;
        end
        if (cmd.load_result)
        begin
            rtt_ns_reg           <= rtt_reg;
            rtt_found_reg        <= found_reg;
            gap_loss_reg         <= gap_reg;
            loss_total_reg       <= loss_sum_reg;
            receive_count_reg    <= rows_reg;
            rtt_sample_count_reg <= matches_reg;
        end
    end

    assign result_valid     = out_valid_reg;
    assign rtt_ns           = rtt_ns_reg;
    assign rtt_found        = rtt_found_reg;
    assign gap_loss         = gap_loss_reg;
    assign loss_total       = loss_total_reg;
    assign receive_count    = receive_count_reg;
    assign rtt_sample_count = rtt_sample_count_reg;

endmodule

// ===== rtl/rtt_and_seq_loss_monitor.sv =====
// Packet exchange monitor: round trip time and sequence-gap loss.
// Item channel (item_valid / item_stall) carries one word per event: func 0
// records an own send (seq_number, time_ns) into the next ring slot, func 1
// reports a peer packet (seq_number, time_ns, acked_seq).
// Result channel (result_valid / result_stall) carries one word per peer
// packet: rtt_ns, rtt_found, gap_loss, loss_total, receive_count,
// rtt_sample_count. Send words give no result.
// Sends can be accepted every cycle while the block is idle.
// A receive word passes through an accumulate state, then a read and a
// compare state per ring slot scanned (lowest slot first, stopping at the
// first match, at most the number of slots written so far), then an emit
// state; the scan is skipped when acked_seq is zero or no send has been
// recorded. Each slot is read from the ring memory into a register first.
// The result word sits in an output register; a new item is taken while it
// waits. While result_stall is high the word holds, and a following receive
// waits in its last cycle until the register frees.
// Reset empties the ring through a fill count (no clearing pass) and clears
// the head slot, the last peer sequence and all counters.
module rtt_and_seq_loss_monitor
#(
    parameter int RING_DEPTH = rslm_pkg::RING_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               func,
    input  logic [31:0]        seq_number,
    input  logic signed [63:0] time_ns,
    input  logic [31:0]        acked_seq,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [63:0] rtt_ns,
    output logic               rtt_found,
    output logic [31:0]        gap_loss,
    output logic [63:0]        loss_total,
    output logic [63:0]        receive_count,
    output logic [63:0]        rtt_sample_count
);

    rslm_pkg::cmd_t    cmd;
    rslm_pkg::status_t status;

    rslm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .func       (func),
        .status     (status),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    rslm_datapath
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .seq_number       (seq_number),
        .time_ns          (time_ns),
        .acked_seq        (acked_seq),
        .result_stall     (result_stall),
        .result_valid     (result_valid),
        .rtt_ns           (rtt_ns),
        .rtt_found        (rtt_found),
        .gap_loss         (gap_loss),
        .loss_total       (loss_total),
        .receive_count    (receive_count),
        .rtt_sample_count (rtt_sample_count)
    );

endmodule

// ===== rtl/rslm_checker.sv =====
`include "assert_macros.svh"

module rslm_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               func,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [63:0] rtt_ns,
    input logic               rtt_found
);

    // a receive word always occupies the block for the following cycle
    `CHK_NEXT(a_recv_busy, clk, rst_n, item_valid && !item_stall && (func == rslm_pkg::FUNC_RECV), item_stall)

    // a send word leaves the block free to take a word in the following cycle
    `CHK_NEXT(a_send_free, clk, rst_n, item_valid && !item_stall && (func == rslm_pkg::FUNC_SEND), !item_stall)

    // no match reports the all-ones rtt
    `CHK_SAME(a_no_match_rtt, clk, rst_n, result_valid && !rtt_found, rtt_ns == rslm_pkg::RTT_NONE)

    // a stalled result word holds
    `CHK_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(rtt_ns))

endmodule

bind rtt_and_seq_loss_monitor rslm_checker u_rslm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rtt_ns       (rtt_ns),
    .rtt_found    (rtt_found)
);

// ===== dv/rtt_and_seq_loss_monitor_tb.sv =====
`timescale 1ns / 100ps

module rtt_and_seq_loss_monitor_tb;

    localparam int RING_SLOTS = rslm_pkg::RING_DEPTH_DEF;
    localparam int RANDOM_WORDS = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam longint unsigned CYCLE_LIMIT = 1_000_000;

    localparam logic signed [63:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] STAMP_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic               fn;
        logic [31:0]        seq;
        logic signed [63:0] stamp;
        logic [31:0]        ack;
    } pkt_t;

    typedef struct {
        logic signed [63:0] rtt;
        logic               found;
        logic [31:0]        gap;
        logic [63:0]        loss;
        logic [63:0]        count;
        logic [63:0]        samples;
    } rtt_report_t;

    typedef struct {
        pkt_t        p;
        bit          pinned;
        rtt_report_t want;
    } recipe_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic               func = rslm_pkg::FUNC_SEND;
    logic [31:0]        seq_number = '0;
    logic signed [63:0] time_ns = '0;
    logic [31:0]        acked_seq = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [63:0] rtt_ns;
    logic               rtt_found;
    logic [31:0]        gap_loss;
    logic [63:0]        loss_total;
    logic [63:0]        receive_count;
    logic [63:0]        rtt_sample_count;

    // shadow of the monitor state
    logic [31:0]        sent_seq [RING_SLOTS];
    logic signed [63:0] sent_stamp [RING_SLOTS];
    int                 head_slot = 0;
    int                 ring_fill = 0;
    logic [31:0]        last_peer = '0;
    bit                 peer_seen = 1'b0;
    logic [63:0]        loss_sum = '0;
    logic [63:0]        rx_count = '0;
    logic [63:0]        sample_count = '0;

    rtt_report_t        pending_reports [$];
    recipe_row_t        recipe [$];

    logic [31:0]        own_seq = 32'd100;
    logic [31:0]        peer_walk_seq = 32'd0;
    logic signed [63:0] clock_now = 64'sd1_000_000;
    int                 burst_left = 0;
    int                 fail_count = 0;
    bit                 hold_off_req = 1'b0;
    bit                 hold_off_done = 1'b0;
    longint unsigned    cycle_count = 0;

    rtt_and_seq_loss_monitor #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .func(func),
        .seq_number(seq_number),
        .time_ns(time_ns),
        .acked_seq(acked_seq),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .rtt_ns(rtt_ns),
        .rtt_found(rtt_found),
        .gap_loss(gap_loss),
        .loss_total(loss_total),
        .receive_count(receive_count),
        .rtt_sample_count(rtt_sample_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            sent_seq[i] = '0;
            sent_stamp[i] = '0;
        end
    end

    // returns 1 when the word yields a result word
    function automatic bit track_packet(input pkt_t p, output rtt_report_t rep);
        logic [31:0] next_expected;
        rep = '{rtt: rslm_pkg::RTT_NONE, found: 1'b0, gap: '0, loss: '0, count: '0,
                samples: '0};
        if (p.fn == rslm_pkg::FUNC_SEND)
        begin
            sent_seq[head_slot] = p.seq;
            sent_stamp[head_slot] = p.stamp;
            head_slot = (head_slot == RING_SLOTS - 1) ? 0 : head_slot + 1;
            if (ring_fill < RING_SLOTS)
                ring_fill++;
            return 1'b0;
        end
        if (peer_seen)
        begin
            next_expected = last_peer + 32'd1;
            if (p.seq > next_expected)
                rep.gap = p.seq - next_expected;
        end
        loss_sum += {32'd0, rep.gap};
        last_peer = p.seq;
        peer_seen = 1'b1;
        // lowest matching slot wins
        if (p.ack != '0)
        begin
            for (int slot = 0; slot < RING_SLOTS && !rep.found; slot++)
            begin
                if (sent_seq[slot] == p.ack)
                begin
                    rep.rtt = p.stamp - sent_stamp[slot];
                    rep.found = 1'b1;
                    sample_count++;
                end
            end
        end
        rx_count++;
        rep.loss = loss_sum;
        rep.count = rx_count;
        rep.samples = sample_count;
        return 1'b1;
    endfunction

    function automatic void add_row(logic fn, logic [31:0] seq, logic signed [63:0] stamp,
                                    logic [31:0] ack);
        recipe_row_t row;
        row.p = '{fn: fn, seq: seq, stamp: stamp, ack: ack};
        row.pinned = 1'b0;
        row.want = '{rtt: '0, found: 1'b0, gap: '0, loss: '0, count: '0, samples: '0};
        recipe.insert(recipe.size(), row);
    endfunction

    function automatic void pin_last(logic signed [63:0] rtt, logic found, logic [31:0] gap,
                                     logic [63:0] loss, logic [63:0] count,
                                     logic [63:0] samples);
        int last;
        last = recipe.size() - 1;
        recipe[last].pinned = 1'b1;
        recipe[last].want = '{rtt: rtt, found: found, gap: gap, loss: loss, count: count,
                              samples: samples};
    endfunction

    function automatic pkt_t next_packet();
        pkt_t p;
        int pick;
        pick = $urandom_range(0, 99);
        p.fn = (pick < 45) ? rslm_pkg::FUNC_SEND : rslm_pkg::FUNC_RECV;
        clock_now += $urandom_range(1, 3000);
        p.stamp = clock_now;
        if ($urandom_range(0, 29) == 0)
            p.stamp = {$urandom, $urandom};
        if (p.fn == rslm_pkg::FUNC_SEND)
        begin
            own_seq += ($urandom_range(0, 9) == 0) ? $urandom_range(2, 50) : 1;
            p.seq = ($urandom_range(0, 39) == 0) ? $urandom : own_seq;
            p.ack = $urandom;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                peer_walk_seq += 1;
            else if (pick < 85)
                peer_walk_seq += $urandom_range(2, 40);
            else if (pick < 92)
                peer_walk_seq -= $urandom_range(0, 5);
            else if (pick < 96)
                peer_walk_seq = 32'hFFFF_FFFF - $urandom_range(0, 8);
            else
                peer_walk_seq = $urandom;
            p.seq = peer_walk_seq;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                p.ack = '0;
            else if (pick < 70 && ring_fill > 0)
                p.ack = sent_seq[$urandom_range(0, ring_fill - 1)];
            else if (pick < 85)
                p.ack = own_seq - $urandom_range(0, 3);
            else
                p.ack = $urandom;
        end
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input pkt_t p, input bit pinned, input rtt_report_t want);
        rtt_report_t predicted;
        item_valid <= 1'b1;
        func <= p.fn;
        seq_number <= p.seq;
        time_ns <= p.stamp;
        acked_seq <= p.ack;
        do
            @(posedge clk);
        while (item_stall);
        if (track_packet(p, predicted))
            pending_reports.insert(pending_reports.size(), pinned ? want : predicted);
        @(negedge clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin : word_source
        rtt_report_t spare;
        int hold_at;
        spare = '{rtt: '0, found: 1'b0, gap: '0, loss: '0, count: '0, samples: '0};
        hold_at = $urandom_range(200, 1200);

        // first receive, then a lookup into an empty ring
        add_row(rslm_pkg::FUNC_RECV, 32'd5, 64'sd1000, 32'd0);
        pin_last(rslm_pkg::RTT_NONE, 1'b0, 32'd0, 64'd0, 64'd1, 64'd0);
        add_row(rslm_pkg::FUNC_RECV, 32'd5, 64'sd1010, 32'd7);
        pin_last(rslm_pkg::RTT_NONE, 1'b0, 32'd0, 64'd0, 64'd2, 64'd0);
        add_row(rslm_pkg::FUNC_SEND, 32'd1, 64'sd100, 32'hFFFF_FFFF);
        add_row(rslm_pkg::FUNC_SEND, 32'hFFFF_FFFF, STAMP_MAX, 32'd0);
        add_row(rslm_pkg::FUNC_SEND, 32'd2, STAMP_MIN, 32'd0);
        // duplicate sequence, slot 0 must still win
        add_row(rslm_pkg::FUNC_SEND, 32'd1, 64'sd500, 32'd0);
        add_row(rslm_pkg::FUNC_SEND, 32'd0, 64'sd7, 32'd0);
        add_row(rslm_pkg::FUNC_RECV, 32'd10, 64'sd1100, 32'd1);
        pin_last(64'sd1000, 1'b1, 32'd4, 64'd4, 64'd3, 64'd1);
        // rtt wraps both ways
        add_row(rslm_pkg::FUNC_RECV, 32'hFFFF_FFFF, STAMP_MIN, 32'hFFFF_FFFF);
        pin_last(64'sd1, 1'b1, 32'hFFFF_FFF4, 64'hFFFF_FFF8, 64'd4, 64'd2);
        add_row(rslm_pkg::FUNC_RECV, 32'd0, 64'sd0, 32'd2);
        pin_last(STAMP_MIN, 1'b1, 32'd0, 64'hFFFF_FFF8, 64'd5, 64'd3);
        add_row(rslm_pkg::FUNC_RECV, 32'd3, 64'sd50, 32'd3);
        // reorder, and a zero ack while a slot holds zero
        add_row(rslm_pkg::FUNC_RECV, 32'd2, 64'sd60, 32'd0);
        add_row(rslm_pkg::FUNC_RECV, 32'h8000_0000, STAMP_MAX, 32'd1);
        add_row(rslm_pkg::FUNC_RECV, 32'h8000_0001, STAMP_MAX, 32'd2);
        add_row(rslm_pkg::FUNC_SEND, 32'h5555_5555, 64'sh5555_5555_5555_5555, 32'd0);
        add_row(rslm_pkg::FUNC_SEND, 32'hAAAA_AAAA, 64'shAAAA_AAAA_AAAA_AAAA, 32'd0);
        add_row(rslm_pkg::FUNC_RECV, 32'hAAAA_AAAA, 64'sh2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        add_row(rslm_pkg::FUNC_RECV, 32'hAAAA_AAAB, -64'sd1, 32'h5555_5555);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (recipe[i])
        begin
            offer(recipe[i].p, recipe[i].pinned, recipe[i].want);
            pace();
        end
        peer_walk_seq = 32'hAAAA_AAAB;

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == hold_at)
                hold_off_req = 1'b1;
            offer(next_packet(), 1'b0, spare);
            pace();
        end
        item_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("rtt_and_seq_loss_monitor_tb OK");
        else
            $display("rtt_and_seq_loss_monitor_tb NOT OK");
        $finish;
    end

    initial
    begin : word_sink
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            if (hold_off_req && !hold_off_done)
            begin
                // long hold-off so the block backs up into its input
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 7) == 0);
                    2: result_stall <= $urandom_range(0, 1);
                    default: result_stall <= ((left % 8) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        rtt_report_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: rtt %0d found %0b gap %0d loss %0d",
                             rtt_ns, rtt_found, gap_loss, loss_total);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (rtt_ns !== want.rtt || rtt_found !== want.found
                    || gap_loss !== want.gap || loss_total !== want.loss
                    || receive_count !== want.count || rtt_sample_count !== want.samples)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch exp: rtt %0d found %0b gap %0d loss %0d count %0d samples %0d",
                                 want.rtt, want.found, want.gap, want.loss, want.count,
                                 want.samples);
                        $display("         got: rtt %0d found %0b gap %0d loss %0d count %0d samples %0d",
                                 rtt_ns, rtt_found, gap_loss, loss_total, receive_count,
                                 rtt_sample_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rtt_and_seq_loss_monitor_tb NOT OK");
            $finish;
        end
    end

endmodule
